// ===== rtl/kldp_pkg.sv =====
// Package for the Kirsch directional pattern unit: pixel and response types,
// register indexes, mask tap layout and the same-popcount rank table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kldp_pkg;

  localparam int NUM_DIR      = 8;
  localparam int WIN_SIZE     = 9;
  localparam int WIN_CENTER   = 4;
  localparam int TAPS_PER_DIR = 3;
  localparam int RESP_W       = 13;
  localparam int TRI_W        = 10;
  localparam int TOT_W        = 11;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int MIN_DIM      = 3;

  typedef logic [7:0]               pix_t;
  typedef logic signed [RESP_W-1:0] resp_t;
  typedef logic [7:0]               rank_tbl_t [256];

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_TOP_COUNT    = 3'd2,
    REG_ABS_MODE     = 3'd3,
    REG_ROTATE_MODE  = 3'd4
  } cfg_reg_t;

  // Window positions weighted by +5 for each direction; the other neighbours weigh -3.
  // Window index is row * 3 + column, top-left first.
  localparam int DIR_TAPS [NUM_DIR][TAPS_PER_DIR] = '{
    '{2, 5, 8},
    '{1, 2, 5},
    '{0, 1, 2},
    '{0, 1, 3},
    '{0, 3, 6},
    '{3, 6, 7},
    '{6, 7, 8},
    '{5, 7, 8}
  };

  // Rank of each byte among all bytes with the same number of ones.
  function automatic rank_tbl_t build_rank_tbl();
    rank_tbl_t   tbl;
    int unsigned seen [9];
    int unsigned n;
    for (int i = 0; i < 9; i++) begin
      seen[i] = 0;
    end
    for (int v = 0; v < 256; v++) begin
      n = $countones(8'(v));
      tbl[v] = 8'(seen[n]);
      seen[n] = seen[n] + 1;
    end
    return tbl;
  endfunction

  localparam rank_tbl_t RANK_TBL = build_rank_tbl();

endpackage

`default_nettype wire

// ===== rtl/kirsch_local_directional_pattern_unit.sv =====
// Kirsch local directional pattern unit: line buffers, 3x3 window and a
// seven-stage code pipeline. Depends on kldp_pkg.
//
// Gray pixels enter in raster order at one item per clock, and the unit keeps
// that rate with the output stalled as long as pipeline stages are free. Each
// pixel that completes an interior 3x3 window yields one code item, passed
// on through stages A to O; border pixels yield nothing. The rate is set by
// the line buffer memories, read once per pixel at accept and written back
// when the pixel leaves the first stage, and by the pipeline behind them (tap
// sums, mask responses, pairwise compares, rank and select, final mapping).
// The line buffers have no reset and no clearing pass; entries are written
// by the first image row before they are ever used. The user must write
// registers only while the unit is idle; the block itself leaves this unchecked.
`timescale 1ns / 1ps
`default_nettype none

module kirsch_local_directional_pattern_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [12:0] cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_pixel,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_pattern_code,
  output logic        out_frame_last
);

  import kldp_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int HW    = 13;
  localparam int ROW_W = 12;

  // configuration
  logic [10:0] image_width_r;
  logic [12:0] image_height_r;
  logic [3:0]  top_count_r;
  logic        abs_mode_r;
  logic        rotate_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= 11'd640;
      image_height_r <= 13'd480;
      top_count_r    <= 4'd3;
      abs_mode_r     <= 1'b1;
      rotate_mode_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[12:0];
        REG_TOP_COUNT:    top_count_r    <= cfg_data[3:0];
        REG_ABS_MODE:     abs_mode_r     <= cfg_data[0];
        REG_ROTATE_MODE:  rotate_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, o_v_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_o;
  logic in_acc, a_move;

  assign rdy_o    = !o_v_r || out_ready;
  assign rdy_f    = !f_v_r || rdy_o;
  assign rdy_e    = !e_v_r || rdy_f;
  assign rdy_d    = !d_v_r || rdy_e;
  assign rdy_c    = !c_v_r || rdy_d;
  assign rdy_b    = !b_v_r || rdy_c;
  assign rdy_a    = !a_v_r || rdy_b;
  assign in_ready = rdy_a;
  assign in_acc   = in_valid && rdy_a;
  assign a_move   = a_v_r && rdy_b;

  // raster position
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WW-1:0]    w_ext, w_last;
  logic [HW-1:0]    h_last;
  logic             last_col, last_row, produce;

  always_comb begin
    w_ext = WW'(image_width_r);
    if (w_ext < WW'(MIN_DIM)) begin
      w_last = WW'(MIN_DIM - 1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_last = WW'(MAX_WIDTH - 1);
    end else begin
      w_last = w_ext - WW'(1);
    end
    if (image_height_r < HW'(MIN_DIM)) begin
      h_last = HW'(MIN_DIM - 1);
    end else if (image_height_r > HW'(HEIGHT_LIMIT)) begin
      h_last = HW'(HEIGHT_LIMIT - 1);
    end else begin
      h_last = image_height_r - HW'(1);
    end
    last_col = WW'(col_r) >= w_last;
    last_row = HW'(row_r) >= h_last;
    produce  = (col_r >= AW'(2)) && (row_r >= ROW_W'(2));
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + AW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage A: accepted pixel and line buffer read
  pix_t          row_above_mem [MAX_WIDTH];
  pix_t          row_two_mem   [MAX_WIDTH];
  pix_t          top_rd_r, mid_rd_r;
  pix_t          a_px_r;
  logic [AW-1:0] a_idx_r;
  logic          a_prod_r, a_last_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      top_rd_r <= row_two_mem[col_r];
      mid_rd_r <= row_above_mem[col_r];
    end
    if (a_move) begin
      row_two_mem[a_idx_r]   <= mid_rd_r;
      row_above_mem[a_idx_r] <= a_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_px_r   <= in_pixel;
      a_idx_r  <= col_r;
      a_prod_r <= produce;
      a_last_r <= last_col && last_row;
    end
  end

  // window columns: [0..2] left column top to bottom, [3..5] middle column
  pix_t wc_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        wc_r[i] <= '0;
      end
    end else if (a_move) begin
      wc_r[0] <= wc_r[3];
      wc_r[1] <= wc_r[4];
      wc_r[2] <= wc_r[5];
      wc_r[3] <= top_rd_r;
      wc_r[4] <= mid_rd_r;
      wc_r[5] <= a_px_r;
    end
  end

  // stage B: full 3x3 window
  pix_t b_win_r [WIN_SIZE];
  logic b_last_r;

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_win_r[0] <= wc_r[0];
      b_win_r[3] <= wc_r[1];
      b_win_r[6] <= wc_r[2];
      b_win_r[1] <= wc_r[3];
      b_win_r[4] <= wc_r[4];
      b_win_r[7] <= wc_r[5];
      b_win_r[2] <= top_rd_r;
      b_win_r[5] <= mid_rd_r;
      b_win_r[8] <= a_px_r;
      b_last_r   <= a_last_r;
    end
  end

  // stage C: per-direction tap sums and neighbor total
  logic [TRI_W-1:0] tri_nxt [NUM_DIR];
  logic [TOT_W-1:0] tot_nxt;
  logic [TRI_W-1:0] c_tri_r [NUM_DIR];
  logic [TOT_W-1:0] c_tot_r;
  logic             c_last_r;

  always_comb begin
    tot_nxt = '0;
    for (int p = 0; p < WIN_SIZE; p++) begin
      if (p != WIN_CENTER) begin
        tot_nxt = tot_nxt + TOT_W'(b_win_r[p]);
      end
    end
    for (int d = 0; d < NUM_DIR; d++) begin
      tri_nxt[d] = TRI_W'(b_win_r[DIR_TAPS[d][0]]) + TRI_W'(b_win_r[DIR_TAPS[d][1]])
                 + TRI_W'(b_win_r[DIR_TAPS[d][2]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && b_v_r) begin
      c_tri_r  <= tri_nxt;
      c_tot_r  <= tot_nxt;
      c_last_r <= b_last_r;
    end
  end

  // stage D: mask responses, 5*taps - 3*others = 8*taps - 3*total
  resp_t resp_nxt [NUM_DIR];
  resp_t d_resp_r [NUM_DIR];
  logic  d_last_r;

  always_comb begin
    for (int d = 0; d < NUM_DIR; d++) begin
      resp_nxt[d] = resp_t'({c_tri_r[d], 3'b000}) - resp_t'(c_tot_r)
                  - resp_t'({c_tot_r, 1'b0});
      if (abs_mode_r && resp_nxt[d][RESP_W-1]) begin
        resp_nxt[d] = -resp_nxt[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && c_v_r) begin
      d_resp_r <= resp_nxt;
      d_last_r <= c_last_r;
    end
  end

  // stage E: which directions outrank each direction; ties go to lower index
  logic [NUM_DIR-1:0] beat_nxt [NUM_DIR];
  logic [NUM_DIR-1:0] elig_nxt;
  logic [NUM_DIR-1:0] e_beat_r [NUM_DIR];
  logic [NUM_DIR-1:0] e_elig_r;
  logic               e_last_r;

  always_comb begin
    for (int j = 0; j < NUM_DIR; j++) begin
      elig_nxt[j] = !d_resp_r[j][RESP_W-1];
      for (int i = 0; i < NUM_DIR; i++) begin
        if (i < j) begin
          beat_nxt[j][i] = d_resp_r[i] >= d_resp_r[j];
        end else if (i > j) begin
          beat_nxt[j][i] = d_resp_r[i] > d_resp_r[j];
        end else begin
          beat_nxt[j][i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && d_v_r) begin
      e_beat_r <= beat_nxt;
      e_elig_r <= elig_nxt;
      e_last_r <= d_last_r;
    end
  end

  // stage F: raw code and strongest direction
  logic [NUM_DIR-1:0] code_nxt;
  logic [2:0]         first_nxt;
  logic               fill;
  logic [7:0]         f_code_r;
  logic [2:0]         f_first_r;
  logic               f_last_r;

  always_comb begin
    first_nxt = '0;
    fill      = 4'($countones(e_elig_r)) < top_count_r;
    for (int j = 0; j < NUM_DIR; j++) begin
      code_nxt[j] = e_elig_r[j] && (4'($countones(e_beat_r[j])) < top_count_r);
      if (e_elig_r[j] && (e_beat_r[j] == '0)) begin
        first_nxt = first_nxt | 3'(j);
      end
    end
    code_nxt[0] = code_nxt[0] | fill;
  end

  always_ff @(posedge clk) begin
    if (rdy_f && e_v_r) begin
      f_code_r  <= code_nxt;
      f_first_r <= first_nxt;
      f_last_r  <= e_last_r;
    end
  end

  // stage O: rotation, zero code, rank mapping
  logic [15:0] rot_dbl;
  logic [7:0]  rot_code, mapped_code;
  logic [7:0]  o_code_r;
  logic        o_last_r;

  always_comb begin
    rot_dbl  = {f_code_r, f_code_r} >> f_first_r;
    rot_code = rotate_mode_r ? rot_dbl[7:0] : f_code_r;
    if (rot_code == 8'd0) begin
      rot_code = 8'hFF;
    end
    if (4'($countones(rot_code)) == top_count_r) begin
      mapped_code = RANK_TBL[rot_code];
    end else begin
      mapped_code = rot_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && f_v_r) begin
      o_code_r <= mapped_code;
      o_last_r <= f_last_r;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_valid;
      if (rdy_b) b_v_r <= a_v_r && a_prod_r;
      if (rdy_c) c_v_r <= b_v_r;
      if (rdy_d) d_v_r <= c_v_r;
      if (rdy_e) e_v_r <= d_v_r;
      if (rdy_f) f_v_r <= e_v_r;
      if (rdy_o) o_v_r <= f_v_r;
    end
  end

  assign out_valid        = o_v_r;
  assign out_pattern_code = o_code_r;
  assign out_frame_last   = o_last_r;

endmodule

`default_nettype wire
